// ===== src/tspmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspmt_pkg
// Types and constants shared by the program map table section parser.
// ----------------------------------------------------------------------------
package tspmt_pkg;

  localparam int unsigned POS_W = 4;
  localparam int unsigned LEN_W = 12;
  localparam int unsigned PID_W = 13;

  localparam logic [7:0] PMT_TABLE_ID = 8'h02;

  // header bytes that close a field, counted from the table id byte
  localparam logic [POS_W-1:0] POS_SECTION_LEN  = 4'd2;
  localparam logic [POS_W-1:0] POS_PROG_NUM     = 4'd4;
  localparam logic [POS_W-1:0] POS_VERSION      = 4'd5;
  localparam logic [POS_W-1:0] POS_SECTION_NUM  = 4'd6;
  localparam logic [POS_W-1:0] POS_LAST_SECTION = 4'd7;
  localparam logic [POS_W-1:0] POS_PCR_PID      = 4'd9;
  localparam logic [POS_W-1:0] POS_PROG_INFO    = 4'd11;

  // entry header bytes
  localparam logic [POS_W-1:0] POS_ES_TYPE      = 4'd0;
  localparam logic [POS_W-1:0] POS_ES_PID       = 4'd2;
  localparam logic [POS_W-1:0] POS_ES_INFO      = 4'd4;

  localparam logic [POS_W-1:0] POS_CRC_LAST     = 4'd3;

  localparam logic [LEN_W:0]   SECTION_OVERHEAD = 13'd13;
  localparam logic [LEN_W-1:0] ES_ENTRY_LEN     = 12'd5;

  typedef enum logic [2:0] {
    KIND_ENTRY   = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_BAD_ID  = 3'd2,
    KIND_TRUNC   = 3'd3,
    KIND_BAD_LEN = 3'd4
  } record_kind_t;

endpackage
`default_nettype wire

// ===== src/ts_pmt_section_parser.sv =====
// a byte taken goes into the input register, and its record into the output register
// throughput: one byte per cycle unless a record waits on a stalled output register
// an input register and an output register sit on the two channels; out_stall reaches in_stall combinationally
// reset clears the parse phase and counters and the valid bits of both pipeline registers
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ts_pmt_section_parser
// Byte-serial parser for program map table sections: header capture,
// descriptor skipping, elementary stream entries and trailing crc word.
// ----------------------------------------------------------------------------
module ts_pmt_section_parser (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    section_start,
  input  wire logic                    buffer_end,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output tspmt_pkg::record_kind_t      record_kind,
  output logic [7:0]                   stream_type,
  output logic [12:0]                  elementary_pid,
  output logic [11:0]                  es_info_length,
  output logic [15:0]                  program_number,
  output logic [4:0]                   version_number,
  output logic                         current_next,
  output logic [7:0]                   section_number,
  output logic [7:0]                   last_section_number,
  output logic [12:0]                  pcr_pid,
  output logic [11:0]                  program_info_length,
  output logic [31:0]                  crc_word
);
  import tspmt_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_SKIP_PROG,
    PH_ENTRY,
    PH_SKIP_ES,
    PH_CRC
  } phase_t;

  // input register
  logic             in_q_valid;
  logic [7:0]       in_q_byte;
  logic             in_q_start;
  logic             in_q_end;

  // parse state
  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] section_len, section_len_next;
  logic [LEN_W-1:0] skip_rem, skip_rem_next;
  logic [LEN_W-1:0] streams_rem, streams_rem_next;
  logic [31:0]      crc_shift, crc_shift_next;

  logic [15:0]      hdr_prog_num, hdr_prog_num_next;
  logic [4:0]       hdr_version, hdr_version_next;
  logic             hdr_cur_next, hdr_cur_next_next;
  logic [7:0]       hdr_sec_num, hdr_sec_num_next;
  logic [7:0]       hdr_last_sec, hdr_last_sec_next;
  logic [PID_W-1:0] hdr_pcr_pid, hdr_pcr_pid_next;
  logic [LEN_W-1:0] hdr_pil, hdr_pil_next;

  logic [7:0]       es_type, es_type_next;
  logic [PID_W-1:0] es_pid, es_pid_next;
  logic [LEN_W-1:0] es_info, es_info_next;

  logic             rec;
  record_kind_t     kind;
  logic             adv;

  always_comb begin
    logic             active;
    logic [LEN_W:0]   need;
    logic [LEN_W-1:0] pil_c;
    logic [LEN_W-1:0] eil_c;
    logic [LEN_W-1:0] left_c;
    active            = 1'b1;
    need              = '0;
    pil_c             = '0;
    eil_c             = '0;
    left_c            = '0;
    rec               = 1'b0;
    kind              = KIND_ENTRY;
    phase_next        = phase;
    pos_next          = pos;
    section_len_next  = section_len;
    skip_rem_next     = skip_rem;
    streams_rem_next  = streams_rem;
    crc_shift_next    = crc_shift;
    hdr_prog_num_next = hdr_prog_num;
    hdr_version_next  = hdr_version;
    hdr_cur_next_next = hdr_cur_next;
    hdr_sec_num_next  = hdr_sec_num;
    hdr_last_sec_next = hdr_last_sec;
    hdr_pcr_pid_next  = hdr_pcr_pid;
    hdr_pil_next      = hdr_pil;
    es_type_next      = es_type;
    es_pid_next       = es_pid;
    es_info_next      = es_info;

    if (in_q_start) begin
      phase_next       = PH_IDLE;
      pos_next         = '0;
      section_len_next = '0;
      skip_rem_next    = '0;
      streams_rem_next = '0;
      crc_shift_next   = '0;
      if (in_q_byte != PMT_TABLE_ID) begin
        rec  = 1'b1;
        kind = KIND_BAD_ID;
      end else begin
        phase_next = PH_HDR;
        pos_next   = POS_W'(1);
      end
    end else begin
      crc_shift_next = {crc_shift[23:0], in_q_byte};
      unique case (phase)
        PH_HDR: begin
          pos_next = pos + 1'b1;
          case (pos)
            POS_SECTION_LEN:  section_len_next  = crc_shift_next[LEN_W-1:0];
            POS_PROG_NUM:     hdr_prog_num_next = crc_shift_next[15:0];
            POS_VERSION: begin
              hdr_version_next  = in_q_byte[5:1];
              hdr_cur_next_next = in_q_byte[0];
            end
            POS_SECTION_NUM:  hdr_sec_num_next  = in_q_byte;
            POS_LAST_SECTION: hdr_last_sec_next = in_q_byte;
            POS_PCR_PID:      hdr_pcr_pid_next  = crc_shift_next[PID_W-1:0];
            POS_PROG_INFO: begin
              pil_c        = crc_shift_next[LEN_W-1:0];
              need         = SECTION_OVERHEAD + {1'b0, pil_c};
              hdr_pil_next = pil_c;
              if ({1'b0, section_len} < need) begin
                rec  = 1'b1;
                kind = KIND_BAD_LEN;
              end else begin
                left_c           = section_len - need[LEN_W-1:0];
                streams_rem_next = left_c;
                pos_next         = '0;
                if (pil_c != '0) begin
                  skip_rem_next = pil_c;
                  phase_next    = PH_SKIP_PROG;
                end else begin
                  phase_next = (left_c != '0) ? PH_ENTRY : PH_CRC;
                end
              end
            end
            default: ;
          endcase
        end
        PH_SKIP_PROG, PH_SKIP_ES: begin
          skip_rem_next = skip_rem - 1'b1;
          if (skip_rem_next == '0) begin
            pos_next   = '0;
            phase_next = (streams_rem != '0) ? PH_ENTRY : PH_CRC;
          end
        end
        PH_ENTRY: begin
          pos_next = pos + 1'b1;
          case (pos)
            POS_ES_TYPE: begin
              if (streams_rem < ES_ENTRY_LEN) begin
                rec  = 1'b1;
                kind = KIND_BAD_LEN;
              end else begin
                streams_rem_next = streams_rem - ES_ENTRY_LEN;
                es_type_next     = in_q_byte;
                es_pid_next      = '0;
                es_info_next     = '0;
              end
            end
            POS_ES_PID: es_pid_next = crc_shift_next[PID_W-1:0];
            POS_ES_INFO: begin
              eil_c        = crc_shift_next[LEN_W-1:0];
              es_info_next = eil_c;
              if (eil_c > streams_rem) begin
                rec  = 1'b1;
                kind = KIND_BAD_LEN;
              end else begin
                left_c           = streams_rem - eil_c;
                streams_rem_next = left_c;
                rec              = 1'b1;
                kind             = KIND_ENTRY;
                pos_next         = '0;
                if (eil_c != '0) begin
                  skip_rem_next = eil_c;
                  phase_next    = PH_SKIP_ES;
                end else begin
                  phase_next = (left_c != '0) ? PH_ENTRY : PH_CRC;
                end
              end
            end
            default: ;
          endcase
        end
        PH_CRC: begin
          if (pos >= POS_CRC_LAST) begin
            rec        = 1'b1;
            kind       = KIND_DONE;
            phase_next = PH_IDLE;
          end else begin
            pos_next = pos + 1'b1;
          end
        end
        default: begin
          active     = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (rec && (kind == KIND_BAD_ID || kind == KIND_BAD_LEN)) begin
      phase_next = PH_IDLE;
    end else if (active && in_q_end && !(rec && kind == KIND_DONE)) begin
      rec        = 1'b1;
      kind       = KIND_TRUNC;
      phase_next = PH_IDLE;
    end
  end

  // a byte moves on when it makes no record or the output register is free
  assign adv      = in_q_valid && (!rec || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid  <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_IDLE;
      pos         <= '0;
      section_len <= '0;
      skip_rem    <= '0;
      streams_rem <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_q_valid <= 1'b1;
      end else if (adv) begin
        in_q_valid <= 1'b0;
      end

      if (adv) begin
        phase       <= phase_next;
        pos         <= pos_next;
        section_len <= section_len_next;
        skip_rem    <= skip_rem_next;
        streams_rem <= streams_rem_next;
      end

      if (adv && rec) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte  <= data_byte;
      in_q_start <= section_start;
      in_q_end   <= buffer_end;
    end

    if (adv) begin
      crc_shift    <= crc_shift_next;
      hdr_prog_num <= hdr_prog_num_next;
      hdr_version  <= hdr_version_next;
      hdr_cur_next <= hdr_cur_next_next;
      hdr_sec_num  <= hdr_sec_num_next;
      hdr_last_sec <= hdr_last_sec_next;
      hdr_pcr_pid  <= hdr_pcr_pid_next;
      hdr_pil      <= hdr_pil_next;
      es_type      <= es_type_next;
      es_pid       <= es_pid_next;
      es_info      <= es_info_next;
    end

    if (adv && rec) begin
      record_kind         <= kind;
      stream_type         <= '0;
      elementary_pid      <= '0;
      es_info_length      <= '0;
      program_number      <= '0;
      version_number      <= '0;
      current_next        <= 1'b0;
      section_number      <= '0;
      last_section_number <= '0;
      pcr_pid             <= '0;
      program_info_length <= '0;
      crc_word            <= '0;
      if (kind == KIND_ENTRY) begin
        stream_type    <= es_type_next;
        elementary_pid <= es_pid_next;
        es_info_length <= es_info_next;
      end
      if (kind == KIND_ENTRY || kind == KIND_DONE) begin
        program_number      <= hdr_prog_num_next;
        version_number      <= hdr_version_next;
        current_next        <= hdr_cur_next_next;
        section_number      <= hdr_sec_num_next;
        last_section_number <= hdr_last_sec_next;
        pcr_pid             <= hdr_pcr_pid_next;
        program_info_length <= hdr_pil_next;
      end
      if (kind == KIND_DONE) begin
        crc_word <= crc_shift_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output register can take a transfer");

  a_entry_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_kind != KIND_ENTRY) |->
      (stream_type == '0 && elementary_pid == '0 && es_info_length == '0))
    else $error("stream entry fields set on a non-entry record");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (record_kind == KIND_BAD_ID || record_kind == KIND_BAD_LEN ||
                   record_kind == KIND_TRUNC)) |->
      (program_number == '0 && pcr_pid == '0 && crc_word == '0))
    else $error("header or crc fields set on an error record");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_ts_pmt_section_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ts_pmt_section_parser
// Feeds program map table sections byte by byte, whole and damaged, with
// bursty input and a stalling output, predicts every record the parser must
// give and compares each received record field by field.
// ----------------------------------------------------------------------------
module tb_ts_pmt_section_parser;
  import tspmt_pkg::*;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;
  localparam int STIM_BYTES  = 1300;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HEADER, ST_PROG_DESC, ST_ES_HEADER, ST_ES_DESC, ST_CRC
  } parse_state_t;

  typedef struct packed {
    record_kind_t kind;
    logic [7:0]   stype;
    logic [12:0]  es_pid;
    logic [11:0]  es_len;
    logic [15:0]  prog;
    logic [4:0]   ver;
    logic         cn;
    logic [7:0]   sec_num;
    logic [7:0]   last_sec;
    logic [12:0]  pcr;
    logic [11:0]  pil;
    logic [31:0]  crc;
  } pmt_record_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       ends;
    logic       hold;
  } pmt_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        section_start = 1'b0;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  record_kind_t record_kind;
  logic [7:0]  stream_type;
  logic [12:0] elementary_pid;
  logic [11:0] es_info_length;
  logic [15:0] program_number;
  logic [4:0]  version_number;
  logic        current_next;
  logic [7:0]  section_number;
  logic [7:0]  last_section_number;
  logic [12:0] pcr_pid;
  logic [11:0] program_info_length;
  logic [31:0] crc_word;

  pmt_byte_t   byte_queue[$];
  pmt_record_t records_due[$];
  logic [7:0]  sec_bytes[$];
  int          parsed_bytes = 0;
  int          err_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_level = 0;
  int          stall_window = 0;

  // parser image
  parse_state_t     pst = ST_IDLE;
  logic [POS_W-1:0] pos = '0;
  logic [11:0]      sec_len = '0;
  logic [11:0]      skip_left = '0;
  logic [11:0]      loop_left = '0;
  logic [31:0]      crc_sr = '0;
  pmt_record_t      fields = '0;

  ts_pmt_section_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .section_start(section_start), .buffer_end(buffer_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .record_kind(record_kind), .stream_type(stream_type),
    .elementary_pid(elementary_pid), .es_info_length(es_info_length),
    .program_number(program_number), .version_number(version_number),
    .current_next(current_next), .section_number(section_number),
    .last_section_number(last_section_number), .pcr_pid(pcr_pid),
    .program_info_length(program_info_length), .crc_word(crc_word)
  );

  always #5 clk = ~clk;

  function void enter_stream_loop();
    pos = '0;
    pst = (loop_left != 0) ? ST_ES_HEADER : ST_CRC;
  endfunction

  task automatic parse_pmt_byte(input logic [7:0] b, input logic st, input logic en);
    pmt_record_t rec;
    logic        have;
    logic        active;
    int          need;
    rec = '0;
    have = 1'b0;
    active = 1'b1;
    if (st) begin
      pst = ST_IDLE;
      pos = '0;
      sec_len = '0;
      skip_left = '0;
      loop_left = '0;
      crc_sr = '0;
      fields = '0;
      if (b != PMT_TABLE_ID) begin
        have = 1'b1;
        rec.kind = KIND_BAD_ID;
      end else begin
        pst = ST_HEADER;
        pos = POS_W'(1);
      end
    end else begin
      crc_sr = {crc_sr[23:0], b};
      case (pst)
        ST_HEADER: begin
          case (pos)
            POS_SECTION_LEN: sec_len = crc_sr[11:0];
            POS_PROG_NUM: fields.prog = crc_sr[15:0];
            POS_VERSION: begin
              fields.ver = b[5:1];
              fields.cn = b[0];
            end
            POS_SECTION_NUM: fields.sec_num = b;
            POS_LAST_SECTION: fields.last_sec = b;
            POS_PCR_PID: fields.pcr = crc_sr[12:0];
            POS_PROG_INFO: begin
              fields.pil = crc_sr[11:0];
              need = int'(SECTION_OVERHEAD) + int'(fields.pil);
              if (int'(sec_len) < need) begin
                have = 1'b1;
                rec.kind = KIND_BAD_LEN;
              end else begin
                loop_left = 12'(int'(sec_len) - need);
                if (fields.pil != 0) begin
                  skip_left = fields.pil;
                  pst = ST_PROG_DESC;
                end else begin
                  enter_stream_loop();
                end
              end
            end
            default: ;
          endcase
          if (pst == ST_HEADER) pos = pos + 1'b1;
        end
        ST_PROG_DESC, ST_ES_DESC: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == 0) enter_stream_loop();
        end
        ST_ES_HEADER: begin
          if (pos == POS_ES_TYPE) begin
            if (loop_left < ES_ENTRY_LEN) begin
              have = 1'b1;
              rec.kind = KIND_BAD_LEN;
            end else begin
              loop_left = loop_left - ES_ENTRY_LEN;
              fields.stype = b;
              fields.es_pid = '0;
              fields.es_len = '0;
              pos = pos + 1'b1;
            end
          end else if (pos == POS_ES_INFO) begin
            fields.es_len = crc_sr[11:0];
            if (fields.es_len > loop_left) begin
              have = 1'b1;
              rec.kind = KIND_BAD_LEN;
            end else begin
              loop_left = loop_left - fields.es_len;
              have = 1'b1;
              rec.kind = KIND_ENTRY;
              if (fields.es_len != 0) begin
                skip_left = fields.es_len;
                pst = ST_ES_DESC;
              end else begin
                enter_stream_loop();
              end
            end
          end else begin
            if (pos == POS_ES_PID) fields.es_pid = crc_sr[12:0];
            pos = pos + 1'b1;
          end
        end
        ST_CRC: begin
          if (pos >= POS_CRC_LAST) begin
            have = 1'b1;
            rec.kind = KIND_DONE;
            pst = ST_IDLE;
          end else begin
            pos = pos + 1'b1;
          end
        end
        default: begin
          active = 1'b0;
          pst = ST_IDLE;
        end
      endcase
    end

    if (have && (rec.kind == KIND_BAD_ID || rec.kind == KIND_BAD_LEN)) begin
      pst = ST_IDLE;
    end else if (active && en && !(have && rec.kind == KIND_DONE)) begin
      have = 1'b1;
      rec.kind = KIND_TRUNC;
      pst = ST_IDLE;
    end

    if (have) begin
      if (rec.kind == KIND_ENTRY) begin
        rec.stype = fields.stype;
        rec.es_pid = fields.es_pid;
        rec.es_len = fields.es_len;
      end
      if (rec.kind == KIND_ENTRY || rec.kind == KIND_DONE) begin
        rec.prog = fields.prog;
        rec.ver = fields.ver;
        rec.cn = fields.cn;
        rec.sec_num = fields.sec_num;
        rec.last_sec = fields.last_sec;
        rec.pcr = fields.pcr;
        rec.pil = fields.pil;
      end
      if (rec.kind == KIND_DONE) rec.crc = crc_sr;
      records_due.push_back(rec);
    end
  endtask

  function automatic logic [31:0] field_val(input int fill, input int bits);
    logic [31:0] mask;
    mask = 32'hffff_ffff >> (32 - bits);
    case (fill)
      FILL_ZERO: return '0;
      FILL_ONES: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] data, input logic first, input logic ends,
                            input logic hold);
    pmt_byte_t item;
    item.data = data;
    item.first = first;
    item.ends = ends;
    item.hold = hold;
    byte_queue.push_back(item);
  endtask

  // whole section with correct lengths, left in sec_bytes
  task automatic build_section(input int n_es, input int pil, input int eil_max,
                               input int fill);
    logic [31:0] v;
    logic [11:0] len12;
    logic [11:0] eil;
    sec_bytes.delete();
    sec_bytes.push_back(PMT_TABLE_ID);
    sec_bytes.push_back(8'h00);
    sec_bytes.push_back(8'h00);
    v = field_val(fill, 16);
    sec_bytes.push_back(v[15:8]);
    sec_bytes.push_back(v[7:0]);
    repeat (3) sec_bytes.push_back(8'(field_val(fill, 8)));
    v = field_val(fill, 16);
    sec_bytes.push_back(v[15:8]);
    sec_bytes.push_back(v[7:0]);
    len12 = 12'(pil);
    v = field_val(fill, 4);
    sec_bytes.push_back({v[3:0], len12[11:8]});
    sec_bytes.push_back(len12[7:0]);
    repeat (pil) sec_bytes.push_back(8'(field_val(fill, 8)));
    repeat (n_es) begin
      sec_bytes.push_back(8'(field_val(fill, 8)));
      v = field_val(fill, 16);
      sec_bytes.push_back(v[15:8]);
      sec_bytes.push_back(v[7:0]);
      eil = 12'($urandom_range(0, eil_max));
      v = field_val(fill, 4);
      sec_bytes.push_back({v[3:0], eil[11:8]});
      sec_bytes.push_back(eil[7:0]);
      repeat (eil) sec_bytes.push_back(8'(field_val(fill, 8)));
    end
    repeat (4) sec_bytes.push_back(8'(field_val(fill, 8)));
    len12 = 12'(sec_bytes.size() - 3);
    v = field_val(fill, 4);
    sec_bytes[1] = {v[3:0], len12[11:8]};
    sec_bytes[2] = len12[7:0];
  endtask

  task automatic send_section(input int upto, input logic end_last, input logic hold);
    for (int i = 0; i < upto; i++) begin
      queue_byte(sec_bytes[i], i == 0, end_last && i == upto - 1, hold && i == 0);
      parsed_bytes++;
    end
  endtask

  // sender: bursts and gaps, optional hold until every record is in
  always @(posedge clk) begin : byte_feed
    pmt_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_pmt_byte(data_byte, section_start, buffer_end);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].hold && records_due.size() != 0)) begin
          nxt = byte_queue.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          section_start <= nxt.first;
          buffer_end <= nxt.ends;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, density changes per window
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_window == 0) begin
        stall_level = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        stall_window = $urandom_range(10, 80);
      end else begin
        stall_window--;
      end
      out_stall <= ($urandom_range(0, 7) < stall_level);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      err_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin : record_check
    pmt_record_t want;
    if (!rst && out_valid && !out_stall) begin
      if (records_due.size() == 0) begin
        err_count++;
        $display("%0t: record_kind expected none actual %0h", $time, record_kind);
      end else begin
        want = records_due.pop_front();
        compare_field("record_kind", 32'(want.kind), 32'(record_kind));
        compare_field("stream_type", 32'(want.stype), 32'(stream_type));
        compare_field("elementary_pid", 32'(want.es_pid), 32'(elementary_pid));
        compare_field("es_info_length", 32'(want.es_len), 32'(es_info_length));
        compare_field("program_number", 32'(want.prog), 32'(program_number));
        compare_field("version_number", 32'(want.ver), 32'(version_number));
        compare_field("current_next", 32'(want.cn), 32'(current_next));
        compare_field("section_number", 32'(want.sec_num), 32'(section_number));
        compare_field("last_section_number", 32'(want.last_sec),
                      32'(last_section_number));
        compare_field("pcr_pid", 32'(want.pcr), 32'(pcr_pid));
        compare_field("program_info_length", 32'(want.pil), 32'(program_info_length));
        compare_field("crc_word", want.crc, crc_word);
      end
    end
  end

  initial begin : stimulus
    int n_es;
    int pil;
    int eil_max;
    int fill;
    int choice;
    int flaw;
    int len;
    logic hold;
    logic [7:0] hi_b;
    logic [7:0] lo_b;
    logic [11:0] len12;

    // bytes outside a section, bad table ids, truncation on the table id
    queue_byte(8'hff, 1'b0, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b1, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0, 1'b0);
    queue_byte(PMT_TABLE_ID, 1'b1, 1'b1, 1'b0);
    // program info length too large for the section
    build_section(0, 0, 0, FILL_ONES);
    sec_bytes[10] = 8'hff;
    sec_bytes[11] = 8'hff;
    send_section(12, 1'b0, 1'b0);
    // all-ones entry, buffer end on the last crc byte
    build_section(1, 0, 0, FILL_ONES);
    send_section(sec_bytes.size(), 1'b1, 1'b0);
    // all-zero section with no entries, sent after a full drain
    build_section(0, 0, 0, FILL_ZERO);
    send_section(sec_bytes.size(), 1'b0, 1'b1);
    // entry info length beyond the stream loop
    build_section(1, 0, 0, FILL_RANDOM);
    sec_bytes[15] = 8'hff;
    sec_bytes[16] = 8'hff;
    send_section(17, 1'b0, 1'b0);
    // stream loop with too few bytes for an entry
    build_section(1, 0, 0, FILL_RANDOM);
    sec_bytes[1] = {sec_bytes[1][7:4], 4'h0};
    sec_bytes[2] = 8'd16;
    send_section(13, 1'b0, 1'b0);
    // buffer end on the byte that completes an entry
    build_section(1, 2, 0, FILL_RANDOM);
    send_section(19, 1'b1, 1'b0);
    // new section start in the middle of a section
    build_section(2, 0, 3, FILL_RANDOM);
    send_section(8, 1'b0, 1'b0);
    build_section(2, 1, 3, FILL_RANDOM);
    send_section(sec_bytes.size(), 1'b0, 1'b0);

    parsed_bytes = 0;
    while (parsed_bytes < STIM_BYTES) begin
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        repeat ($urandom_range(1, 4))
          queue_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
      end else if (choice < 13) begin
        queue_byte(($urandom_range(0, 3) == 0) ? PMT_TABLE_ID : 8'($urandom), 1'b1,
                   $urandom_range(0, 3) == 0, 1'b0);
        parsed_bytes++;
      end else begin
        n_es = $urandom_range(0, 4);
        pil = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        eil_max = 6;
        if ($urandom_range(0, 39) == 0) pil = $urandom_range(100, 400);
        if ($urandom_range(0, 39) == 0) eil_max = 400;
        fill = FILL_RANDOM;
        if ($urandom_range(0, 15) == 0) fill = $urandom_range(FILL_ZERO, FILL_ONES);
        build_section(n_es, pil, eil_max, fill);
        hold = ($urandom_range(0, 24) == 0);
        flaw = $urandom_range(0, 99);
        if (flaw < 12) begin
          send_section($urandom_range(1, sec_bytes.size()), 1'b1, hold);
        end else if (flaw < 20) begin
          send_section($urandom_range(1, sec_bytes.size() - 1), 1'b0, hold);
        end else begin
          if (flaw < 30) begin
            hi_b = sec_bytes[1];
            lo_b = sec_bytes[2];
            len = {hi_b[3:0], lo_b};
            len = len + int'($urandom_range(0, 16)) - 8;
            if (len < 0) len = 0;
            if (len > 4095) len = 4095;
            len12 = 12'(len);
            sec_bytes[1] = {hi_b[7:4], len12[11:8]};
            sec_bytes[2] = len12[7:0];
          end else if (flaw < 36) begin
            sec_bytes[$urandom_range(3, sec_bytes.size() - 1)] = 8'($urandom);
          end else if (flaw < 40) begin
            sec_bytes[0] = 8'($urandom);
          end
          send_section(sec_bytes.size(), $urandom_range(0, 3) == 0, hold);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
    while (records_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_ts_pmt_section_parser: clean");
    end else begin
      $display("tb_ts_pmt_section_parser: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_ts_pmt_section_parser: errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/tspmt_pkg.sv
src/ts_pmt_section_parser.sv
tb/tb_ts_pmt_section_parser.sv
